/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WELL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define WELL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define WELL_ASSERT(lbl, clk, rstn, prop)

`define WELL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* hdl/well1024a_pkg.sv */
// ----------------------------------------------------------------------------
// WELL1024a package
// Constants, opcodes, controller states and command bundle.
// ----------------------------------------------------------------------------
package well1024a_pkg;

    localparam int WORDS  = 32;
    localparam int IDX_W  = 5;
    localparam int WORD_W = 32;
    localparam int BOUND_W = 31;

    localparam logic [IDX_W-1:0]  FILL_LAST = IDX_W'(WORDS - 1);
    localparam logic [WORD_W-1:0] SEED_MULT = 32'd69069;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'd1;

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    typedef enum logic [2:0] {
        ST_SEED,
        ST_FILL,
        ST_IDLE,
        ST_MULT
    } state_t;

    typedef struct packed {
        logic take_item;
        logic draw;
        logic load_seed;
        logic fill_shift;
        logic load_out;
    } cmd_t;

endpackage

/* hdl/well1024a_ctrl.sv */
// ----------------------------------------------------------------------------
// WELL1024a controller
// Sequences reset fill, reseed fill, draw and output load.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module well1024a_ctrl
    import well1024a_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_tuser,
    output logic s_tready,
    input  logic m_tready,
    output logic m_tvalid,
    output cmd_t cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             accept;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_SEED: begin
                state_next = ST_FILL;
                cnt_next   = '0;
            end
            ST_FILL: begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == FILL_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == OP_RESEED) ? ST_SEED : ST_MULT;
                end
            end
            ST_MULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_SEED;
            end
        endcase
    end

    always_comb begin
        cmd.take_item  = accept;
        cmd.draw       = accept && (s_tuser == OP_DRAW);
        cmd.load_seed  = (state_reg == ST_SEED);
        cmd.fill_shift = (state_reg == ST_FILL);
        cmd.load_out   = (state_reg == ST_MULT) && out_free;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        priority if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SEED;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `WELL_ASSERT(a_load_when_free, aclk, aresetn, cmd.load_out |-> (!out_valid_reg || m_tready))
    `WELL_ASSERT(a_draw_to_mult, aclk, aresetn, cmd.draw |=> (state_reg == ST_MULT))
    `WELL_ASSERT(a_fill_ends, aclk, aresetn, (state_reg == ST_FILL && cnt_reg == FILL_LAST) |=> (state_reg == ST_IDLE))
    `WELL_ASSERT_ALWAYS(a_reset_seeds, aclk, !aresetn |=> (state_reg == ST_SEED))

endmodule

/* hdl/well1024a_dp.sv */
// ----------------------------------------------------------------------------
// WELL1024a datapath
// Rotating state line, seed fill, recurrence and bounded scaling.
// ----------------------------------------------------------------------------
module well1024a_dp
    import well1024a_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    input  cmd_t        cmd,
    input  logic [31:0] s_tdata,
    output logic [63:0] m_tdata
);

    logic [WORD_W-1:0]  seed_reg;
    logic [WORD_W-1:0]  fill_reg, fill_next;
    logic [BOUND_W-1:0] bound_reg;
    logic [WORD_W-1:0]  words_reg [WORDS];
    logic [WORD_W-1:0]  words_next [WORDS];
    logic [WORD_W-1:0]  z1, z2, new_cur, new_prev;
    logic [62:0]        prod;
    logic [63:0]        out_reg;

    assign z1 = words_reg[0] ^ (words_reg[3] ^ (words_reg[3] >> 8));
    assign z2 = (words_reg[24] ^ (words_reg[24] << 19))
              ^ (words_reg[10] ^ (words_reg[10] << 14));
    assign new_cur  = z1 ^ z2;
    assign new_prev = (words_reg[WORDS-1] ^ (words_reg[WORDS-1] << 11))
                    ^ (z1 ^ (z1 << 7)) ^ (z2 ^ (z2 << 13));

    assign fill_next = WORD_W'(fill_reg * SEED_MULT);

    always_comb begin
        for (int k = 0; k < WORDS; k++) begin
            words_next[k] = words_reg[k];
        end
        priority if (cmd.fill_shift) begin
            for (int k = 0; k < WORDS - 1; k++) begin
                words_next[k] = words_reg[k+1];
            end
            words_next[WORDS-1] = fill_reg;
        end else if (cmd.draw) begin
            words_next[0] = new_prev;
            words_next[1] = new_cur;
            for (int k = 2; k < WORDS; k++) begin
                words_next[k] = words_reg[k-1];
            end
        end
    end

    assign prod = 63'(words_reg[0]) * 63'(bound_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else if (cfg_valid) begin
            seed_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_seed) begin
            fill_reg <= seed_reg;
        end else if (cmd.fill_shift) begin
            fill_reg <= fill_next;
        end
        if (cmd.take_item) begin
            bound_reg <= s_tdata[BOUND_W-1:0];
        end
        if (cmd.load_out) begin
            out_reg <= {1'b0, prod[62:32], words_reg[0]};
        end
        for (int k = 0; k < WORDS; k++) begin
            words_reg[k] <= words_next[k];
        end
    end

    assign m_tdata = out_reg;

endmodule

/* hdl/well1024a_random_generator.sv */
// ----------------------------------------------------------------------------
// WELL1024a random generator
// Draws WELL1024a words with a bounded integer form; reseeds from a register.
// ----------------------------------------------------------------------------
//  channel  ports                          content (low bit first)
//  in       s_tvalid s_tready s_tuser      tuser: op; tdata: bound, pad
//           s_tdata[31:0]
//  out      m_tvalid m_tready m_tdata      tdata: random_word, scaled_value, pad
//  config   cfg_valid cfg_ready cfg_data   seed_value
//
//  A draw updates the state line, then registers the word times bound product.
//  A reseed runs the accept cycle, seed load, then one state word
//  shifted in per cycle.
//  After reset a fill (seed load plus 32 shifts) runs with seed 1 before any item is taken.
//  One item at a time; a held result stalls only the multiply stage.
// ----------------------------------------------------------------------------
module well1024a_random_generator
    import well1024a_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // bound[30:0], zero[31]
    input  logic        s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // random_word[31:0], scaled_value[62:32], zero[63]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    well1024a_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    well1024a_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

endmodule

/* dv/well_draw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL1024a draw checker
// Watches the seed, item and result channels, keeps its own copy of the
// generator state, predicts every draw and compares each result in order.
// ----------------------------------------------------------------------------
module well_draw_checker
    import well1024a_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // bound[30:0], zero[31]
    input  logic        s_tuser,   // op[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // random_word[31:0], scaled_value[62:32], zero[63]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [BOUND_W-1:0] scaled;
    } draw_t;

    logic [WORD_W-1:0] well_words [WORDS];
    logic [IDX_W-1:0]  well_index;
    logic [WORD_W-1:0] seed_reg;
    draw_t             expected_draws [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void fill_words(input logic [WORD_W-1:0] seed);
        well_words[0] = seed;
        for (int i = 1; i < WORDS; i++) begin
            well_words[i] = well_words[i-1] * SEED_MULT;
        end
        well_index = '0;
    endfunction

    function automatic void predict_draw(input logic [BOUND_W-1:0] bnd);
        logic [IDX_W-1:0]  n, prev, t1, t2, t3;
        logic [WORD_W-1:0] a, b, c, d, z1, z2, word;
        logic [63:0]       prod;
        draw_t             exp_r;
        n    = well_index;
        prev = n - 5'd1;
        t1   = n + 5'd3;
        t2   = n + 5'd24;
        t3   = n + 5'd10;
        a    = well_words[t1];
        b    = well_words[t2];
        c    = well_words[t3];
        z1   = well_words[n] ^ a ^ (a >> 8);
        z2   = b ^ (b << 19) ^ c ^ (c << 14);
        well_words[n] = z1 ^ z2;
        d    = well_words[prev];
        word = d ^ (d << 11) ^ z1 ^ (z1 << 7) ^ z2 ^ (z2 << 13);
        well_words[prev] = word;
        well_index = prev;
        prod = {32'd0, word} * {33'd0, bnd};
        exp_r.word   = word;
        exp_r.scaled = prod[62:32];
        expected_draws.push_back(exp_r);
    endfunction

    always @(posedge aclk) begin
        draw_t got, exp_r;
        if (!aresetn) begin
            seed_reg = SEED_RESET;
            fill_words(SEED_RESET);
            expected_draws.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.word   = m_tdata[31:0];
                got.scaled = m_tdata[62:32];
                if (expected_draws.size() == 0) begin
                    $display("%0t: unexpected result item, expected none actual %h %h",
                             $time, got.word, got.scaled);
                    fail_count++;
                end else begin
                    exp_r = expected_draws.pop_front();
                    if (got.word !== exp_r.word) begin
                        $display("%0t: random_word expected %h actual %h",
                                 $time, exp_r.word, got.word);
                        fail_count++;
                    end
                    if (got.scaled !== exp_r.scaled) begin
                        $display("%0t: scaled_value expected %h actual %h",
                                 $time, exp_r.scaled, got.scaled);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                seed_reg = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_RESEED) begin
                    fill_words(seed_reg);
                end else begin
                    predict_draw(s_tdata[30:0]);
                end
            end
        end
        pending = expected_draws.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL1024a generator testbench
// Drives directed and random draw and reseed items under varying back
// pressure, rewrites the seed between phases and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    import well1024a_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = OP_DRAW;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    int          fail_count;
    int          pending;
    int          src_idle  = 0;
    int          sink_idle = 0;

    always #2 aclk = ~aclk;

    well1024a_random_generator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    well_draw_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(negedge aclk) begin
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    task automatic send_item(input logic op, input logic [BOUND_W-1:0] bnd);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, bnd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // drain results, then let a pending reseed fill finish
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] seed);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [BOUND_W-1:0] pick_bound();
        case ($urandom_range(7))
            0:       return '0;
            1:       return {BOUND_W{1'b1}};
            2:       return BOUND_W'($urandom_range(15));
            default: return BOUND_W'($urandom);
        endcase
    endfunction

    initial begin
        #2000000;
        $display("tb failed");
        $finish;
    end

    initial begin
        logic [WORD_W-1:0] phase_seed;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_idle  = 26;
        sink_idle = 86;

        // state after reset, bound extremes, reseed with the reset seed
        send_item(OP_DRAW, '0);
        send_item(OP_DRAW, {BOUND_W{1'b1}});
        send_item(OP_DRAW, 31'd1);
        send_item(OP_DRAW, 31'h4000_0000);
        send_item(OP_RESEED, BOUND_W'($urandom));
        send_item(OP_DRAW, {BOUND_W{1'b1}});
        send_item(OP_DRAW, pick_bound());

        // zero seed: every draw returns zero
        settle();
        write_seed('0);
        send_item(OP_RESEED, '0);
        send_item(OP_DRAW, {BOUND_W{1'b1}});
        send_item(OP_DRAW, 31'd12345);
        send_item(OP_DRAW, '0);

        settle();
        write_seed({WORD_W{1'b1}});
        send_item(OP_RESEED, {BOUND_W{1'b1}});
        send_item(OP_DRAW, {BOUND_W{1'b1}});
        send_item(OP_DRAW, 31'd1);
        send_item(OP_RESEED, '0);
        send_item(OP_DRAW, {BOUND_W{1'b1}});

        for (int phase = 0; phase < 3; phase++) begin
            settle();
            case (phase)
                0: begin
                    src_idle   = 26;
                    sink_idle  = 86;
                    phase_seed = $urandom | 32'h1;
                end
                1: begin
                    src_idle   = 86;
                    sink_idle  = 26;
                    phase_seed = $urandom;
                end
                default: begin
                    src_idle   = 0;
                    sink_idle  = 0;
                    phase_seed = SEED_RESET;
                end
            endcase
            write_seed(phase_seed);
            for (int i = 0; i < 300; i++) begin
                if ($urandom_range(99) < 4) begin
                    send_item(OP_RESEED, pick_bound());
                end else begin
                    send_item(OP_DRAW, pick_bound());
                end
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

/* well1024a_random_generator.f */
+incdir+hdl
hdl/well1024a_pkg.sv
hdl/well1024a_ctrl.sv
hdl/well1024a_dp.sv
hdl/well1024a_random_generator.sv
dv/well_draw_checker.sv
dv/tb.sv
